/* rtl/tpc_pkg.sv */
// Shared types and constants for the two-buffer page cache controller.
// No dependencies; used by every module of the block.
package tpc_pkg;

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 21;
  localparam int LEN_W    = 11;
  localparam int PAGE_W   = 13;
  localparam int OFF_W    = 10;
  localparam int CFG_W    = 4;
  localparam int CNT_W    = 4;
  localparam int RESULT_CAP = 15;
  localparam int MIN_BITS = 8;
  localparam int MAX_BITS = 10;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd9;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OP_WRITE_BACK = 2'd0,
    OP_LOAD       = 2'd1,
    OP_BUF_WRITE  = 2'd2,
    OP_BUF_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic               sel;
    logic [PAGE_W-1:0]  page;
    logic [OFF_W-1:0]   offset;
    logic [LEN_W-1:0]   len;
  } res_t;

  typedef struct packed {
    logic               clr_dirty;
    logic               load;
    logic               set_dirty;
    logic               set_last;
    logic               sel;
    logic [PAGE_W-1:0]  page;
  } tag_upd_t;

  typedef struct packed {
    logic               hit;
    logic               hit_sel;
    logic               victim;
    logic               wb_need;
    logic [PAGE_W-1:0]  wb_tag;
  } tag_stat_t;

endpackage

/* rtl/tpc_tags.sv */
// Tag, valid, dirty and last-used state of the two page buffers.
// Depends on tpc_pkg for the update and status structs.
module tpc_tags (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [tpc_pkg::PAGE_W-1:0] look_page,
  input  logic                       query_sel,
  input  tpc_pkg::tag_upd_t          upd,
  output tpc_pkg::tag_stat_t         stat
);

  logic [tpc_pkg::PAGE_W-1:0] tag [2];
  logic [1:0]                 valid;
  logic [1:0]                 dirty;
  logic                       last_used;
  logic                       hit0;
  logic                       hit1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag[0]    <= '0;
      tag[1]    <= '0;
      valid     <= '0;
      dirty     <= '0;
      last_used <= 1'b0;
    end else begin
      if (upd.clr_dirty) dirty[upd.sel] <= 1'b0;
      if (upd.set_dirty) dirty[upd.sel] <= 1'b1;
      if (upd.load) begin
        tag[upd.sel]   <= upd.page;
        valid[upd.sel] <= 1'b1;
      end
      if (upd.set_last) last_used <= upd.sel;
    end
  end

  always_comb begin
    hit0         = valid[0] && (tag[0] == look_page);
    hit1         = valid[1] && (tag[1] == look_page);
    stat.hit     = hit0 || hit1;
    stat.hit_sel = !hit0;
    stat.victim  = ~last_used;
    stat.wb_need = valid[query_sel] && dirty[query_sel];
    stat.wb_tag  = tag[query_sel];
  end

endmodule

/* rtl/tpc_split.sv */
// Address splitter: page number, offset and chunk length of the next chunk.
// Depends on tpc_pkg for field widths.
module tpc_split #(
  parameter int ADDR_BITS = 21
) (
  input  logic [ADDR_BITS-1:0]       addr,
  input  logic [tpc_pkg::LEN_W-1:0]  len,
  input  logic [1:0]                 shift,
  output logic [tpc_pkg::PAGE_W-1:0] page,
  output logic [tpc_pkg::OFF_W-1:0]  offset,
  output logic [tpc_pkg::LEN_W-1:0]  n
);

  logic [ADDR_BITS-1:0]      shifted;
  logic [tpc_pkg::OFF_W-1:0] mask;
  logic [tpc_pkg::LEN_W-1:0] psize;
  logic [tpc_pkg::LEN_W-1:0] room;

  always_comb begin
    case (shift)
      2'd0: begin
        shifted = addr >> 8;
        mask    = 10'h0FF;
        psize   = 11'd256;
      end
      2'd1: begin
        shifted = addr >> 9;
        mask    = 10'h1FF;
        psize   = 11'd512;
      end
      default: begin
        shifted = addr >> 10;
        mask    = 10'h3FF;
        psize   = 11'd1024;
      end
    endcase
    page   = shifted[tpc_pkg::PAGE_W-1:0];
    offset = addr[tpc_pkg::OFF_W-1:0] & mask;
    room   = psize - {1'b0, offset};
    n      = (room > len) ? len : room;
  end

endmodule

/* rtl/two_buffer_page_cache_ctrl_unit.sv */
// Top level of the two-buffer write-back page cache controller.
// Depends on tpc_pkg, tpc_split and tpc_tags.
//
// Usage:
//   A request (command, address, length) is taken at a clock edge where start
//   is high and busy is low. busy stays high until every result of the
//   request has been given.
//   Results appear one per cycle at most on op, buffer_sel, page, offset,
//   chunk_len and last, each marked for a single cycle by result_strobe;
//   last marks the final result of a request. At most 15 results are given.
//   The receiver cannot stall; results must be taken as they appear.
//   Each page chunk goes through split, lookup and access on a hit and
//   through split, lookup, write-back check, load and access on a miss.
//   Each result is held one stage so last can be marked and leaves when the
//   next one is formed or at the end of the request. A flush checks the first
//   buffer and then the second for a write-back.
//   page_offset_bits is written by cfg_write with cfg_data; the user must write
//   it only while idle, as the block itself does not enforce this.
//   Reset (rst, synchronous) empties both buffers, clears dirty marks, makes
//   the first buffer the last used one and sets page_offset_bits to 9.
module two_buffer_page_cache_ctrl_unit #(
  parameter int ADDR_BITS = 21,
  parameter int MAX_LEN   = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [tpc_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       start,
  output logic                       busy,
  input  logic [tpc_pkg::CMD_W-1:0]  command,
  input  logic [tpc_pkg::ADDR_W-1:0] address,
  input  logic [tpc_pkg::LEN_W-1:0]  length,
  output logic                       result_strobe,
  output logic [1:0]                 op,
  output logic                       buffer_sel,
  output logic [tpc_pkg::PAGE_W-1:0] page,
  output logic [tpc_pkg::OFF_W-1:0]  offset,
  output logic [tpc_pkg::LEN_W-1:0]  chunk_len,
  output logic                       last
);

  localparam int LenCmpW = ($clog2(MAX_LEN + 1) > tpc_pkg::LEN_W) ?
                           $clog2(MAX_LEN + 1) : tpc_pkg::LEN_W;
  localparam int ExtW    = 32;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT, S_LOOK, S_WB, S_LOAD, S_ACC, S_FL0, S_FL1, S_FIN
  } state_t;

  state_t                     state;
  logic [tpc_pkg::CFG_W-1:0]  page_offset_bits;
  logic                       is_write;
  logic [ADDR_BITS-1:0]       addr;
  logic [tpc_pkg::LEN_W-1:0]  len;
  logic [tpc_pkg::PAGE_W-1:0] cur_page;
  logic [tpc_pkg::OFF_W-1:0]  cur_off;
  logic [tpc_pkg::LEN_W-1:0]  cur_n;
  logic                       sel;
  logic [tpc_pkg::CNT_W-1:0]  count;
  logic                       pend_valid;
  tpc_pkg::res_t              pend;

  logic [1:0]                 shift;
  logic [ExtW-1:0]            addr_ext;
  logic [tpc_pkg::LEN_W-1:0]  len_eff;
  logic [tpc_pkg::PAGE_W-1:0] sp_page;
  logic [tpc_pkg::OFF_W-1:0]  sp_off;
  logic [tpc_pkg::LEN_W-1:0]  sp_n;
  logic                       query_sel;
  tpc_pkg::tag_upd_t          upd;
  tpc_pkg::tag_stat_t         stat;
  logic                       cand_valid;
  tpc_pkg::res_t              cand;
  logic                       accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    if (page_offset_bits < 4'(tpc_pkg::MIN_BITS)) begin
      shift = 2'd0;
    end else if (page_offset_bits > 4'(tpc_pkg::MAX_BITS)) begin
      shift = 2'd2;
    end else begin
      shift = 2'(page_offset_bits - 4'(tpc_pkg::MIN_BITS));
    end
    addr_ext = {{(ExtW - tpc_pkg::ADDR_W){1'b0}}, address};
    if ({{(LenCmpW - tpc_pkg::LEN_W){1'b0}}, length} > LenCmpW'(MAX_LEN)) begin
      len_eff = tpc_pkg::LEN_W'(MAX_LEN);
    end else begin
      len_eff = length;
    end
  end

  tpc_split #(
    .ADDR_BITS(ADDR_BITS)
  ) u_split (
    .addr  (addr),
    .len   (len),
    .shift (shift),
    .page  (sp_page),
    .offset(sp_off),
    .n     (sp_n)
  );

  tpc_tags u_tags (
    .clk      (clk),
    .rst      (rst),
    .look_page(cur_page),
    .query_sel(query_sel),
    .upd      (upd),
    .stat     (stat)
  );

  always_comb begin
    query_sel  = sel;
    upd        = '0;
    upd.sel    = sel;
    upd.page   = cur_page;
    cand_valid = 1'b0;
    cand.op    = tpc_pkg::OP_WRITE_BACK;
    cand.sel   = sel;
    cand.page  = stat.wb_tag;
    cand.offset = '0;
    cand.len   = '0;
    case (state)
      S_WB: begin
        if (stat.wb_need) begin
          cand_valid    = 1'b1;
          upd.clr_dirty = 1'b1;
        end
      end
      S_LOAD: begin
        cand_valid = 1'b1;
        cand.op    = tpc_pkg::OP_LOAD;
        cand.page  = cur_page;
        upd.load   = 1'b1;
      end
      S_ACC: begin
        cand_valid    = 1'b1;
        cand.op       = is_write ? tpc_pkg::OP_BUF_WRITE : tpc_pkg::OP_BUF_READ;
        cand.page     = cur_page;
        cand.offset   = cur_off;
        cand.len      = cur_n;
        upd.set_dirty = is_write;
        upd.set_last  = 1'b1;
      end
      S_FL0: begin
        query_sel = 1'b0;
        upd.sel   = 1'b0;
        cand.sel  = 1'b0;
        if (stat.wb_need) begin
          cand_valid    = 1'b1;
          upd.clr_dirty = 1'b1;
        end
      end
      S_FL1: begin
        query_sel = 1'b1;
        upd.sel   = 1'b1;
        cand.sel  = 1'b1;
        if (stat.wb_need) begin
          cand_valid    = 1'b1;
          upd.clr_dirty = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      page_offset_bits <= tpc_pkg::CFG_RESET;
      count            <= '0;
      pend_valid       <= 1'b0;
      result_strobe    <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_write) page_offset_bits <= cfg_data;

      if (cand_valid && (count < tpc_pkg::CNT_W'(tpc_pkg::RESULT_CAP))) begin
        count <= count + 1'b1;
        pend  <= cand;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          result_strobe <= 1'b1;
          op            <= pend.op;
          buffer_sel    <= pend.sel;
          page          <= pend.page;
          offset        <= pend.offset;
          chunk_len     <= pend.len;
          last          <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            is_write <= (tpc_pkg::cmd_t'(command) == tpc_pkg::CMD_WRITE);
            addr     <= addr_ext[ADDR_BITS-1:0];
            len      <= len_eff;
            case (tpc_pkg::cmd_t'(command))
              tpc_pkg::CMD_READ, tpc_pkg::CMD_WRITE: begin
                state <= (len_eff == '0) ? S_FIN : S_SPLIT;
              end
              tpc_pkg::CMD_FLUSH: state <= S_FL0;
              default:            state <= S_FIN;
            endcase
          end
        end
        S_SPLIT: begin
          cur_page <= sp_page;
          cur_off  <= sp_off;
          cur_n    <= sp_n;
          state    <= S_LOOK;
        end
        S_LOOK: begin
          if (stat.hit) begin
            sel   <= stat.hit_sel;
            state <= S_ACC;
          end else begin
            sel   <= stat.victim;
            state <= S_WB;
          end
        end
        S_WB:   state <= S_LOAD;
        S_LOAD: state <= S_ACC;
        S_ACC: begin
          addr  <= addr + {{(ADDR_BITS - tpc_pkg::LEN_W){1'b0}}, cur_n};
          len   <= len - cur_n;
          state <= (len == cur_n) ? S_FIN : S_SPLIT;
        end
        S_FL0: state <= S_FL1;
        S_FL1: state <= S_FIN;
        S_FIN: begin
          if (pend_valid) begin
            result_strobe <= 1'b1;
            op            <= pend.op;
            buffer_sel    <= pend.sel;
            page          <= pend.page;
            offset        <= pend.offset;
            chunk_len     <= pend.len;
            last          <= 1'b1;
          end
          pend_valid <= 1'b0;
          count      <= '0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for two_buffer_page_cache_ctrl_unit.
// Drives read, write and flush requests, predicts the command stream of the
// page cache and checks it. Depends on tpc_pkg and the RTL of the block.
module tb;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int LEN_CAP       = 1024;

  typedef struct {
    tpc_pkg::cmd_t              cmd;
    logic [tpc_pkg::ADDR_W-1:0] addr;
    logic [tpc_pkg::LEN_W-1:0]  len;
    bit                         drain;
  } flash_req_t;

  typedef struct packed {
    tpc_pkg::op_t               op;
    logic                       sel;
    logic [tpc_pkg::PAGE_W-1:0] page;
    logic [tpc_pkg::OFF_W-1:0]  offset;
    logic [tpc_pkg::LEN_W-1:0]  len;
    logic                       last;
  } flash_cmd_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [tpc_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                       start = 1'b0;
  logic                       busy;
  logic [tpc_pkg::CMD_W-1:0]  command = '0;
  logic [tpc_pkg::ADDR_W-1:0] address = '0;
  logic [tpc_pkg::LEN_W-1:0]  length = '0;
  logic                       result_strobe;
  logic [1:0]                 op;
  logic                       buffer_sel;
  logic [tpc_pkg::PAGE_W-1:0] page;
  logic [tpc_pkg::OFF_W-1:0]  offset;
  logic [tpc_pkg::LEN_W-1:0]  chunk_len;
  logic                       last;

  logic [tpc_pkg::PAGE_W-1:0] tag_m [2] = '{default: '0};
  bit                         valid_m [2] = '{default: 1'b0};
  bit                         dirty_m [2] = '{default: 1'b0};
  bit                         lru_m = 1'b0;
  logic [tpc_pkg::CFG_W-1:0]  page_bits_m = tpc_pkg::CFG_RESET;

  flash_req_t pending [$];
  flash_cmd_t cmd_fifo [$];
  int         req_emits = 0;
  int         idle_pct = 0;
  int         n_req = 0;
  int         n_cmd = 0;
  int         n_wb = 0;
  int         n_load = 0;
  int         errors = 0;
  int         stall_cycles = 0;

  two_buffer_page_cache_ctrl_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .command(command),
    .address(address),
    .length(length),
    .result_strobe(result_strobe),
    .op(op),
    .buffer_sel(buffer_sel),
    .page(page),
    .offset(offset),
    .chunk_len(chunk_len),
    .last(last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void emit_cmd(tpc_pkg::op_t o, bit s,
                                   logic [tpc_pkg::PAGE_W-1:0] pg,
                                   logic [tpc_pkg::OFF_W-1:0] off,
                                   logic [tpc_pkg::LEN_W-1:0] n);
    flash_cmd_t c;
    if (req_emits >= tpc_pkg::RESULT_CAP) return;
    c.op = o;
    c.sel = s;
    c.page = pg;
    c.offset = off;
    c.len = n;
    c.last = 1'b0;
    cmd_fifo.push_back(c);
    req_emits++;
  endfunction

  function automatic void evict_dirty(bit s);
    if (valid_m[s] && dirty_m[s]) begin
      emit_cmd(tpc_pkg::OP_WRITE_BACK, s, tag_m[s], '0, '0);
      dirty_m[s] = 1'b0;
    end
  endfunction

  function automatic void model_request(logic [tpc_pkg::CMD_W-1:0] c,
                                        logic [tpc_pkg::ADDR_W-1:0] a,
                                        logic [tpc_pkg::LEN_W-1:0] l);
    int unsigned                bits, psize, off, n, rem;
    logic [tpc_pkg::ADDR_W-1:0] ptr;
    logic [tpc_pkg::PAGE_W-1:0] pg;
    bit                         s;
    req_emits = 0;
    if (c == tpc_pkg::CMD_NONE) return;
    if (c == tpc_pkg::CMD_FLUSH) begin
      evict_dirty(1'b0);
      evict_dirty(1'b1);
    end else begin
      bits = page_bits_m;
      if (bits < tpc_pkg::MIN_BITS) bits = tpc_pkg::MIN_BITS;
      if (bits > tpc_pkg::MAX_BITS) bits = tpc_pkg::MAX_BITS;
      psize = 1 << bits;
      rem = (l > LEN_CAP) ? LEN_CAP : l;
      ptr = a;
      while (rem > 0) begin
        pg = tpc_pkg::PAGE_W'(ptr >> bits);
        off = ptr & (psize - 1);
        n = psize - off;
        if (n > rem) n = rem;
        if (valid_m[0] && tag_m[0] == pg) begin
          s = 1'b0;
        end else if (valid_m[1] && tag_m[1] == pg) begin
          s = 1'b1;
        end else begin
          s = !lru_m;
          evict_dirty(s);
          emit_cmd(tpc_pkg::OP_LOAD, s, pg, '0, '0);
          tag_m[s] = pg;
          valid_m[s] = 1'b1;
        end
        if (c == tpc_pkg::CMD_WRITE) begin
          emit_cmd(tpc_pkg::OP_BUF_WRITE, s, pg, tpc_pkg::OFF_W'(off),
                   tpc_pkg::LEN_W'(n));
          dirty_m[s] = 1'b1;
        end else begin
          emit_cmd(tpc_pkg::OP_BUF_READ, s, pg, tpc_pkg::OFF_W'(off),
                   tpc_pkg::LEN_W'(n));
        end
        ptr = ptr + tpc_pkg::ADDR_W'(n);
        rem -= n;
        lru_m = s;
      end
    end
    if (req_emits > 0) cmd_fifo[$].last = 1'b1;
  endfunction

  function automatic void flag(string what, flash_cmd_t want, flash_cmd_t got);
    errors++;
    if (errors <= 10)
      $display("tb: %s: want op=%0d sel=%0d page=%0h off=%0d len=%0d last=%0d",
               what, want.op, want.sel, want.page, want.offset, want.len, want.last,
               " / got op=%0d sel=%0d page=%0h off=%0d len=%0d last=%0d",
               got.op, got.sel, got.page, got.offset, got.len, got.last);
  endfunction

  task automatic push_req(tpc_pkg::cmd_t c, logic [tpc_pkg::ADDR_W-1:0] a,
                          logic [tpc_pkg::LEN_W-1:0] l, bit drain);
    flash_req_t r;
    r.cmd = c;
    r.addr = a;
    r.len = l;
    r.drain = drain;
    pending.push_back(r);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || start || busy || cmd_fifo.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_page_bits(logic [tpc_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    page_bits_m = v;
  endtask

  task automatic random_batch(int count);
    logic [tpc_pkg::ADDR_W-1:0] hot_base, a;
    logic [tpc_pkg::LEN_W-1:0]  l;
    tpc_pkg::cmd_t              c;
    int                         k, r;
    hot_base = tpc_pkg::ADDR_W'($urandom);
    k = 0;
    while (k < count) begin
      r = $urandom_range(99);
      c = (r < 42) ? tpc_pkg::CMD_READ :
          (r < 86) ? tpc_pkg::CMD_WRITE :
          (r < 95) ? tpc_pkg::CMD_FLUSH : tpc_pkg::CMD_NONE;
      if ($urandom_range(99) < 75) a = hot_base + tpc_pkg::ADDR_W'($urandom_range(0, 3071));
      else a = tpc_pkg::ADDR_W'($urandom);
      r = $urandom_range(99);
      if (r < 68) l = tpc_pkg::LEN_W'($urandom_range(1, 200));
      else if (r < 88) l = tpc_pkg::LEN_W'($urandom_range(0, 1024));
      else if (r < 94) l = '0;
      else l = tpc_pkg::LEN_W'($urandom_range(1025, 2047));
      push_req(c, a, l, $urandom_range(99) < 4);
      if (c != tpc_pkg::CMD_NONE) k++;
    end
  endtask

  always @(posedge clk) begin : drive_req
    flash_req_t nxt;
    logic       go;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = start && busy;
      if (start && !busy) begin
        model_request(command, address, length);
        n_req++;
      end
      // hold a draining request until the block has gone quiet
      if (!go && pending.size() > 0 && $urandom_range(99) >= idle_pct &&
          !(pending[0].drain && (cmd_fifo.size() != 0 || busy))) begin
        nxt = pending.pop_front();
        go = 1'b1;
        command <= nxt.cmd;
        address <= nxt.addr;
        length <= nxt.len;
      end
      start <= go;
    end
  end

  always @(posedge clk) begin : check_cmd
    flash_cmd_t want, got;
    if (!rst && result_strobe) begin
      got = {op, buffer_sel, page, offset, chunk_len, last};
      n_cmd++;
      if (cmd_fifo.size() == 0) begin
        flag("unexpected command", '0, got);
      end else begin
        want = cmd_fifo.pop_front();
        if (got !== want) flag("mismatch", want, got);
        if (want.op == tpc_pkg::OP_WRITE_BACK) n_wb++;
        if (want.op == tpc_pkg::OP_LOAD) n_load++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || cfg_write) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("tb: stalled, %0d commands still expected", cmd_fifo.size());
    $display("tb: errors");
    $finish;
  end

  initial begin : run
    idle_pct = 30;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_req(tpc_pkg::CMD_READ, 21'h000000, 11'd1, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h0001FF, 11'd2, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h1FFFFF, 11'd1024, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h0003E8, 11'h7FF, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h012345, 11'd0, 1'b0);
    push_req(tpc_pkg::CMD_NONE, 21'h1FFFFF, 11'h7FF, 1'b0);
    push_req(tpc_pkg::CMD_FLUSH, 21'h1FFFFF, 11'h7FF, 1'b1);
    push_req(tpc_pkg::CMD_FLUSH, 21'h000000, 11'd0, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h155555, 11'h2AA, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h0AAAAA, 11'h555, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h000400, 11'd512, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h000800, 11'd512, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h000C00, 11'd16, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h000C10, 11'd16, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h000800, 11'd1, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h100000, 11'd1024, 1'b0);
    push_req(tpc_pkg::CMD_READ, 21'h1FFE00, 11'd1024, 1'b0);
    push_req(tpc_pkg::CMD_FLUSH, 21'h000000, 11'd1, 1'b0);
    push_req(tpc_pkg::CMD_WRITE, 21'h000000, 11'd1024, 1'b0);
    push_req(tpc_pkg::CMD_FLUSH, 21'h000000, 11'd0, 1'b0);
    settle();

    write_page_bits(4'd15);
    random_batch(50);
    settle();
    idle_pct = 69;
    write_page_bits(4'd0);
    random_batch(50);
    settle();
    write_page_bits(4'd8);
    random_batch(50);
    settle();
    idle_pct = 0;
    write_page_bits(4'd10);
    random_batch(50);
    settle();
    write_page_bits(4'd9);
    random_batch(50);
    settle();
    write_page_bits(4'd12);
    random_batch(50);
    settle();

    if (cmd_fifo.size() != 0) begin
      $display("tb: %0d expected commands never arrived", cmd_fifo.size());
      errors += cmd_fifo.size();
    end
    $display("tb: %0d requests, %0d commands checked (%0d write-backs, %0d page loads)",
             n_req, n_cmd, n_wb, n_load);
    $display("tb: page sizes 256 to 1024 bytes, sender idle at 30, 69 and 0 percent");
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

/* two_buffer_page_cache_ctrl_unit.f */
rtl/tpc_pkg.sv
rtl/tpc_tags.sv
rtl/tpc_split.sv
rtl/two_buffer_page_cache_ctrl_unit.sv
tb/sv/tb.sv
